/* sv/vfd_pkg.sv */
// Shared types and constants for the variable frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package vfd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned BodyCntW   = 9;
  localparam int unsigned CmdBytes   = 4;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;

  localparam logic [ByteW-1:0]    MARKER_RESET   = 8'h68;
  localparam logic [BodyCntW-1:0] BODY_EXTRA     = 9'd2;
  localparam logic                REG_START_MARKER = 1'b0;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  // One entry of the front-to-back queue: either a whole released header
  // (four bytes, lowest byte first) or one body byte.
  typedef struct packed {
    logic                          hdr;
    logic                          last;
    logic [CmdBytes*ByteW-1:0]     bytes;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/vfd_front.sv */
// Front end: hunts for the marker, collects the header, classifies bytes.
`timescale 1ns / 1ps
`default_nettype none

module vfd_front
  import vfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [ByteW-1:0] in_byte,
  input  wire logic [ByteW-1:0] marker,
  output logic                  cmd_push,
  output cmd_t                  cmd
);

  phase_t                phase, phase_next;
  logic [1:0]            hcount, hcount_next;
  logic [BodyCntW-1:0]   bytes_left, bytes_left_next;
  logic [ByteW-1:0]      h0, h1, h2;
  logic                  is_marker;
  logic                  body_last;

  assign is_marker = (in_byte == marker);
  assign body_last = (bytes_left <= BodyCntW'(1));

  always_comb begin
    phase_next      = phase;
    hcount_next     = hcount;
    bytes_left_next = bytes_left;
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (hcount != 2'd3) begin
            hcount_next = hcount + 2'd1;
          end else begin
            hcount_next = 2'd0;
            if (!is_marker) begin
              phase_next = PH_HUNT;
            end else begin
              phase_next      = PH_BODY;
              bytes_left_next = {1'b0, h1} + BODY_EXTRA;
            end
          end
        end
        PH_BODY: begin
          if (body_last) begin
            bytes_left_next = '0;
            phase_next      = PH_HUNT;
          end else begin
            bytes_left_next = bytes_left - BodyCntW'(1);
          end
        end
        default: begin
          if (is_marker) begin
            phase_next  = PH_HEADER;
            hcount_next = 2'd1;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_comb begin
    cmd_push  = 1'b0;
    cmd.hdr   = 1'b0;
    cmd.last  = 1'b0;
    cmd.bytes = {{(CmdBytes-1)*ByteW{1'b0}}, in_byte};
    unique case (phase)
      PH_HEADER: begin
        cmd_push  = accept && (hcount == 2'd3) && is_marker;
        cmd.hdr   = 1'b1;
        cmd.bytes = {in_byte, h2, h1, h0};
      end
      PH_BODY: begin
        cmd_push = accept;
        cmd.last = body_last;
      end
      default: begin
        cmd_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      hcount     <= 2'd0;
      bytes_left <= '0;
    end else begin
      phase      <= phase_next;
      hcount     <= hcount_next;
      bytes_left <= bytes_left_next;
    end
  end

  // Header bytes need no reset: each is written before it is used.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (phase == PH_HEADER && hcount != 2'd3) begin
        case (hcount)
          2'd0:    h0 <= in_byte;
          2'd1:    h1 <= in_byte;
          default: h2 <= in_byte;
        endcase
      end else if (phase != PH_HEADER && phase != PH_BODY && is_marker) begin
        h0 <= in_byte;
      end
    end
  end

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> bytes_left != '0)
    else $error("body phase with no bytes left");

  a_header_release: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && cmd.hdr) |=> (phase == PH_BODY && hcount == 2'd0))
    else $error("header released without entering body");

endmodule

`default_nettype wire

/* sv/vfd_cmd_fifo.sv */
// Short queue of commands between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module vfd_cmd_fifo
  import vfd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic rd,
  output cmd_t      rdata,
  output logic      avail
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  cmd_t            entries [DEPTH];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign full  = (count == CntW'(DEPTH));
  assign avail = (count != '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && avail;
  assign rdata = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LastPtr) ? '0 : wptr + PtrW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == LastPtr) ? '0 : rptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full))
    else $error("command written into a full queue");

endmodule

`default_nettype wire

/* sv/vfd_back.sv */
// Back end: expands queued commands into output words, one per pop.
`timescale 1ns / 1ps
`default_nettype none

module vfd_back
  import vfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_avail,
  input  wire cmd_t             cmd,
  output logic                  cmd_pop,
  output logic                  empty,
  input  wire logic             pop,
  output logic [ByteW-1:0]      frame_byte,
  output logic                  frame_first,
  output logic                  frame_last
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       word_taken;
  logic       cmd_done;

  assign empty      = !cur_valid;
  assign word_taken = pop && cur_valid;
  assign cmd_done   = word_taken && (!cur.hdr || idx == 2'd3);
  assign cmd_pop    = cmd_avail && (!cur_valid || cmd_done);

  always_comb begin
    case (idx)
      2'd0:    frame_byte = cur.bytes[0*ByteW +: ByteW];
      2'd1:    frame_byte = cur.bytes[1*ByteW +: ByteW];
      2'd2:    frame_byte = cur.bytes[2*ByteW +: ByteW];
      default: frame_byte = cur.bytes[3*ByteW +: ByteW];
    endcase
  end

  assign frame_first = cur.hdr && (idx == 2'd0);
  assign frame_last  = !cur.hdr && cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (cmd_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (cmd_done) begin
      cur_valid <= 1'b0;
    end else if (word_taken) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !pop) |=> (cur_valid && $stable(idx)))
    else $error("stalled word moved");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(frame_first && frame_last))
    else $error("word marked both first and last");

endmodule

`default_nettype wire

/* sv/variable_frame_deframer.sv */
// Top level of the variable frame deframer.
//
// Input channel: a byte is taken at a clock edge where push is high and full is
// low. Output channel: while empty is low the oldest waiting word (frame_byte,
// frame_first, frame_last) is on the ports and leaves at an edge with pop high.
// The APB port holds start_marker at byte address 0 (reset value 0x68).
//
// The front end hunts for the marker and collects the header; a byte that
// completes a valid four-byte header releases all four header words at once,
// and each later body byte releases one word, the last after L+6 frame bytes.
// Headers with a bad fourth byte are dropped without output.
// A taken byte is registered in the command queue and then in the back end's
// current command before it shows. One byte per cycle goes in while full is
// low, one word per cycle comes out while empty is low and pop is high; the
// four header words leave one per pop from a single queue entry (CMD_DEPTH
// entries). When pop stays low the queue fills and full rises. Synchronous
// reset returns to hunting, empties the queue and restores the marker register.
`timescale 1ns / 1ps
`default_nettype none

module variable_frame_deframer
  import vfd_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [ByteW-1:0] data_byte,
  output logic                  empty,
  input  wire logic             pop,
  output logic [ByteW-1:0]      frame_byte,
  output logic                  frame_first,
  output logic                  frame_last,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  logic [ByteW-1:0] start_marker;
  logic             accept;
  logic             cmd_push;
  cmd_t             cmd_in;
  cmd_t             cmd_out;
  logic             cmd_full;
  logic             cmd_avail;
  logic             cmd_pop;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_START_MARKER);
  assign prdata  = reg_sel ? {{(DataW-ByteW){1'b0}}, start_marker} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= MARKER_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      start_marker <= pwdata[ByteW-1:0];
    end
  end

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  vfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (data_byte),
    .marker   (start_marker),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  vfd_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .rd    (cmd_pop),
    .rdata (cmd_out),
    .avail (cmd_avail)
  );

  vfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_avail   (cmd_avail),
    .cmd         (cmd_out),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .frame_byte  (frame_byte),
    .frame_first (frame_first),
    .frame_last  (frame_last)
  );

endmodule

`default_nettype wire
